// ----- sv/dcc_packet_receiver_defines.svh -----
`ifndef DCC_PACKET_RECEIVER_DEFINES_SVH
`define DCC_PACKET_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS
`define DCC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define DCC_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define DCC_ASSERT(lbl, prop, msg)
`define DCC_NEVER(lbl, cond, msg)
`endif

`endif

// ----- sv/dcc_pkg.sv -----
package dcc_pkg;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [19:0] TIMER_MAX = 20'hFFFFF;

   localparam logic [1:0] CSR_PREAMBLE_MIN   = 2'd0;
   localparam logic [1:0] CSR_PACKET_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_SIGNAL_TIMEOUT = 2'd2;

   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_FINAL  = 2'd1;
   localparam logic [1:0] KIND_ABORT  = 2'd2;
   localparam logic [1:0] KIND_SIGNAL = 2'd3;

   localparam logic [1:0] STATUS_GOOD     = 2'd0;
   localparam logic [1:0] STATUS_BAD      = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic       CMD_SAMPLE = 1'b0;
   localparam logic       CMD_TICK   = 1'b1;

   localparam logic [3:0] PAT_ONE_A  = 4'hD;
   localparam logic [3:0] PAT_ONE_B  = 4'h7;
   localparam logic [3:0] PAT_ZERO_A = 4'h8;
   localparam logic [3:0] PAT_ZERO_B = 4'h2;

   // classified beat handed from front to back
   typedef struct packed {
      logic is_tick;
      logic has_bit;
      logic bit_val;
   } op_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic [5:0] byte_index;
      logic [1:0] packet_status;
      logic       signal_ok;
      logic       last;
   } rsp_type;

   function automatic rsp_type make_rsp(logic [1:0] kind, logic [7:0] data,
                                        logic [5:0] idx, logic [1:0] status);
      rsp_type r;
      r.kind          = kind;
      r.data_byte     = data;
      r.byte_index    = idx;
      r.packet_status = status;
      r.signal_ok     = 1'b0;
      r.last          = 1'b0;
      return r;
   endfunction

endpackage

// ----- sv/dcc_front.sv -----
module dcc_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic            req_cmd,
   input  logic [3:0]      req_edge_pattern,
   output logic            op_valid,
   output dcc_pkg::op_type op,
   input  logic            op_pop
);

   dcc_pkg::op_type               queue_ff [dcc_pkg::QDEPTH];
   logic [dcc_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [dcc_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [dcc_pkg::QCNT_W-1:0]    count_ff, count_in;
   dcc_pkg::op_type               op_dec;
   logic                          push;

   assign req_stall = (count_ff == dcc_pkg::QCNT_W'(dcc_pkg::QDEPTH));
   assign push      = req_valid && !req_stall;
   assign op_valid  = (count_ff != '0);
   assign op        = queue_ff[rd_ptr_ff];

   // pattern classification
   always_comb begin
      op_dec.is_tick = (req_cmd == dcc_pkg::CMD_TICK);
      op_dec.has_bit = 1'b0;
      op_dec.bit_val = 1'b0;
      if (req_cmd == dcc_pkg::CMD_SAMPLE) begin
         case (req_edge_pattern)
            dcc_pkg::PAT_ONE_A, dcc_pkg::PAT_ONE_B: begin
               op_dec.has_bit = 1'b1;
               op_dec.bit_val = 1'b1;
            end
            dcc_pkg::PAT_ZERO_A, dcc_pkg::PAT_ZERO_B: begin
               op_dec.has_bit = 1'b1;
            end
            default: begin
               op_dec.has_bit = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff + dcc_pkg::QPTR_W'(1);
      rd_ptr_in = rd_ptr_ff + dcc_pkg::QPTR_W'(1);
      count_in  = count_ff;
      if (push && !op_pop) begin
         count_in = count_ff + dcc_pkg::QCNT_W'(1);
      end else if (!push && op_pop) begin
         count_in = count_ff - dcc_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (op_pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= op_dec;
      end
   end

endmodule

// ----- sv/dcc_back.sv -----
`include "dcc_packet_receiver_defines.svh"

module dcc_back #(
   parameter int MAX_BYTES = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [19:0]      csr_wdata,
   input  logic             op_valid,
   input  dcc_pkg::op_type  op,
   input  logic             space_ok,
   output logic             fire,
   output logic [1:0]       push_cnt,
   output dcc_pkg::rsp_type res0,
   output dcc_pkg::rsp_type res1
);

   localparam logic [5:0] MAX_CNT = 6'(MAX_BYTES);

   logic [4:0]  preamble_min_ff;
   logic [19:0] packet_timeout_ff;
   logic [19:0] signal_timeout_ff;

   logic [4:0]  ones_run_ff, ones_run_in;
   logic        in_pkt_ff, in_pkt_in;
   logic [3:0]  bit_pos_ff, bit_pos_in;
   logic [7:0]  shift_ff, shift_in;
   logic [5:0]  byte_cnt_ff, byte_cnt_in;
   logic [7:0]  xor_ff, xor_in;
   logic        ovf_ff, ovf_in;
   logic [19:0] pkt_idle_ff, pkt_idle_in;
   logic [19:0] bit_idle_ff, bit_idle_in;
   logic        present_ff, present_in;

   dcc_pkg::rsp_type res [2];
   logic [1:0]       n;
   logic             opened;
   logic             ok;
   logic [1:0]       status;

   assign fire = op_valid && space_ok;

   always_comb begin
      ones_run_in = ones_run_ff;
      in_pkt_in   = in_pkt_ff;
      bit_pos_in  = bit_pos_ff;
      shift_in    = shift_ff;
      byte_cnt_in = byte_cnt_ff;
      xor_in      = xor_ff;
      ovf_in      = ovf_ff;
      pkt_idle_in = pkt_idle_ff;
      bit_idle_in = bit_idle_ff;
      present_in  = present_ff;
      res[0]      = dcc_pkg::make_rsp(dcc_pkg::KIND_DATA, 8'd0, 6'd0, dcc_pkg::STATUS_GOOD);
      res[1]      = res[0];
      n           = 2'd0;
      opened      = 1'b0;
      ok          = 1'b0;
      status      = dcc_pkg::STATUS_GOOD;
      if (!op.is_tick) begin
         if (op.has_bit) begin
            bit_idle_in = '0;
            if (op.bit_val) begin
               if (ones_run_ff != 5'd31) begin
                  ones_run_in = ones_run_ff + 5'd1;
               end
            end else if (ones_run_ff >= preamble_min_ff && !in_pkt_ff) begin
               opened      = 1'b1;
               in_pkt_in   = 1'b1;
               bit_pos_in  = '0;
               shift_in    = '0;
               byte_cnt_in = '0;
               xor_in      = '0;
               ovf_in      = 1'b0;
               pkt_idle_in = '0;
               ones_run_in = '0;
            end else begin
               ones_run_in = '0;
            end
            if (!opened && in_pkt_ff) begin
               if (bit_pos_ff < 4'd8) begin
                  shift_in   = {shift_ff[6:0], op.bit_val};
                  bit_pos_in = bit_pos_ff + 4'd1;
               end else begin
                  xor_in      = xor_ff ^ shift_ff;
                  pkt_idle_in = '0;
                  ovf_in      = ovf_ff || (byte_cnt_ff >= MAX_CNT);
                  if (op.bit_val) begin
                     if (ovf_in) begin
                        status = dcc_pkg::STATUS_OVERFLOW;
                     end else if (xor_in != 8'd0) begin
                        status = dcc_pkg::STATUS_BAD;
                     end
                     res[n[0]] = dcc_pkg::make_rsp(dcc_pkg::KIND_FINAL, shift_ff,
                                                   byte_cnt_ff, status);
                     n           = n + 2'd1;
                     in_pkt_in   = 1'b0;
                     byte_cnt_in = '0;
                  end else if (byte_cnt_ff < MAX_CNT) begin
                     res[n[0]] = dcc_pkg::make_rsp(dcc_pkg::KIND_DATA, shift_ff,
                                                   byte_cnt_ff, dcc_pkg::STATUS_GOOD);
                     n           = n + 2'd1;
                     byte_cnt_in = byte_cnt_ff + 6'd1;
                  end
                  bit_pos_in = '0;
                  shift_in   = '0;
               end
            end
         end
         ok = (bit_idle_in < signal_timeout_ff);
         if (ok != present_ff) begin
            present_in = ok;
            res[n[0]]  = dcc_pkg::make_rsp(dcc_pkg::KIND_SIGNAL, 8'd0, 6'd0,
                                           dcc_pkg::STATUS_GOOD);
            n          = n + 2'd1;
         end
      end else begin
         if (bit_idle_ff != dcc_pkg::TIMER_MAX) begin
            bit_idle_in = bit_idle_ff + 20'd1;
         end
         ok = (bit_idle_in < signal_timeout_ff);
         if (ok != present_ff) begin
            present_in = ok;
            res[n[0]]  = dcc_pkg::make_rsp(dcc_pkg::KIND_SIGNAL, 8'd0, 6'd0,
                                           dcc_pkg::STATUS_GOOD);
            n          = n + 2'd1;
         end
         if (in_pkt_ff) begin
            if (pkt_idle_ff != dcc_pkg::TIMER_MAX) begin
               pkt_idle_in = pkt_idle_ff + 20'd1;
            end
            if (pkt_idle_in > packet_timeout_ff) begin
               res[n[0]]   = dcc_pkg::make_rsp(dcc_pkg::KIND_ABORT, 8'd0, byte_cnt_ff,
                                               dcc_pkg::STATUS_GOOD);
               n           = n + 2'd1;
               in_pkt_in   = 1'b0;
               bit_pos_in  = '0;
               shift_in    = '0;
               byte_cnt_in = '0;
            end
         end
      end
      res[0].signal_ok = present_in;
      res[1].signal_ok = present_in;
      res[0].last      = (n == 2'd1);
      res[1].last      = (n == 2'd2);
   end

   assign push_cnt = fire ? n : 2'd0;
   assign res0     = res[0];
   assign res1     = res[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_min_ff   <= 5'd12;
         packet_timeout_ff <= 20'd100000;
         signal_timeout_ff <= 20'd100000;
      end else if (csr_we) begin
         case (csr_index)
            dcc_pkg::CSR_PREAMBLE_MIN:   preamble_min_ff   <= csr_wdata[4:0];
            dcc_pkg::CSR_PACKET_TIMEOUT: packet_timeout_ff <= csr_wdata;
            dcc_pkg::CSR_SIGNAL_TIMEOUT: signal_timeout_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ones_run_ff <= '0;
         in_pkt_ff   <= 1'b0;
         bit_pos_ff  <= '0;
         shift_ff    <= '0;
         byte_cnt_ff <= '0;
         xor_ff      <= '0;
         ovf_ff      <= 1'b0;
         pkt_idle_ff <= '0;
         bit_idle_ff <= '0;
         present_ff  <= 1'b0;
      end else if (fire) begin
         ones_run_ff <= ones_run_in;
         in_pkt_ff   <= in_pkt_in;
         bit_pos_ff  <= bit_pos_in;
         shift_ff    <= shift_in;
         byte_cnt_ff <= byte_cnt_in;
         xor_ff      <= xor_in;
         ovf_ff      <= ovf_in;
         pkt_idle_ff <= pkt_idle_in;
         bit_idle_ff <= bit_idle_in;
         present_ff  <= present_in;
      end
   end

   `DCC_ASSERT(a_close_on_fire, $fell(in_pkt_ff) |-> $past(fire), "packet closed without a beat")
   `DCC_NEVER(a_cnt_bound, byte_cnt_ff > MAX_CNT, "byte count past limit")
   `DCC_ASSERT(a_pos_bound, in_pkt_ff |-> bit_pos_ff <= 4'd8, "bit position past separator")
   `DCC_NEVER(a_tick_no_byte, fire && op.is_tick && n != 2'd0 && res0.kind == dcc_pkg::KIND_DATA, "tick made a byte")

endmodule

// ----- sv/dcc_rsp_fifo.sv -----
`include "dcc_packet_receiver_defines.svh"

module dcc_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_cnt,
   input  dcc_pkg::rsp_type res0,
   input  dcc_pkg::rsp_type res1,
   output logic             space_ok,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dcc_pkg::rsp_type rsp
);

   dcc_pkg::rsp_type            mem_ff [dcc_pkg::QDEPTH];
   logic [dcc_pkg::QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [dcc_pkg::QPTR_W-1:0]  wr_ptr_nx;
   logic [dcc_pkg::QCNT_W-1:0]  count_ff, count_in;
   logic                        pop;

   // room for the two results one beat can make
   assign space_ok  = (count_ff <= dcc_pkg::QCNT_W'(dcc_pkg::QDEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign rsp       = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign wr_ptr_nx = wr_ptr_ff + dcc_pkg::QPTR_W'(1);

   always_comb begin
      count_in = count_ff + dcc_pkg::QCNT_W'(push_cnt) - dcc_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_ff + dcc_pkg::QPTR_W'(push_cnt);
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + dcc_pkg::QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= res0;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_ptr_nx] <= res1;
      end
   end

   `DCC_NEVER(a_fifo_bound, count_ff > dcc_pkg::QCNT_W'(dcc_pkg::QDEPTH), "result queue overrun")

endmodule

// ----- sv/dcc_packet_receiver.sv -----
// DCC packet receiver: decodes edge-pattern samples into bits, frames them into
// packets and reports each byte, the final byte with its checksum verdict, packet
// aborts and signal presence changes. A beat enters every cycle while the
// four-entry op queue has room; each beat is executed once the result queue
// has two free slots, and results leave one per cycle while rsp_stall is low,
// so the two results of one beat leave one after the other. Sustained rate is
// one beat per cycle when results are taken at least as fast as they are made.
module dcc_packet_receiver #(
   parameter int MAX_BYTES = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [3:0]  req_edge_pattern,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [5:0]  rsp_byte_index,
   output logic [1:0]  rsp_packet_status,
   output logic        rsp_signal_ok,
   output logic        rsp_last
);

   logic             op_valid;
   dcc_pkg::op_type  op;
   logic             fire;
   logic             space_ok;
   logic [1:0]       push_cnt;
   dcc_pkg::rsp_type res0, res1, rsp;

   dcc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_edge_pattern (req_edge_pattern),
      .op_valid         (op_valid),
      .op               (op),
      .op_pop           (fire)
   );

   dcc_back #(
      .MAX_BYTES (MAX_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .op_valid  (op_valid),
      .op        (op),
      .space_ok  (space_ok),
      .fire      (fire),
      .push_cnt  (push_cnt),
      .res0      (res0),
      .res1      (res1)
   );

   dcc_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .res0      (res0),
      .res1      (res1),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_kind          = rsp.kind;
   assign rsp_data_byte     = rsp.data_byte;
   assign rsp_byte_index    = rsp.byte_index;
   assign rsp_packet_status = rsp.packet_status;
   assign rsp_signal_ok     = rsp.signal_ok;
   assign rsp_last          = rsp.last;

endmodule
